// ----- hw/rtl/hdlctx_pkg.sv -----
// Shared types and constants for the HDLC transmit bit encoder.
`timescale 1ns / 1ps

package hdlctx_pkg;

   // Result queue depth; the request side keeps room for two items of two results each.
   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_STUFFED = 3'd0,
      CMD_COUNTED = 3'd1,
      CMD_RAW     = 3'd2,
      CMD_SAVE    = 3'd3,
      CMD_RESTORE = 3'd4,
      CMD_FLUSH   = 3'd5,
      CMD_RESET   = 3'd6
   } cmd_type;

   // Member order gives the checkpoint layout: ones_run in the low bits,
   // scrambler_reg in the high bits.
   typedef struct packed {
      logic [16:0] scrambler_reg;
      logic [7:0]  partial_bits;
      logic [2:0]  fill_count;
      logic        line_level;
      logic [7:0]  ones_run;
   } coder_state_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic [3:0] out_bits;
      logic       last;
   } result_type;

   // Results produced by one request, in order r0 then r1.
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } result_pair_type;

endpackage

// ----- hw/rtl/hdlctx_coder.sv -----
// Combinational bit stuffing, NRZI and scrambler step for one request.
`timescale 1ns / 1ps

module hdlctx_coder (
   input  hdlctx_pkg::coder_state_type cur_state,
   input  hdlctx_pkg::coder_state_type cur_saved,
   input  logic                        scramble_en,
   input  logic [2:0]                  cmd,
   input  logic [7:0]                  data_byte,
   output hdlctx_pkg::coder_state_type next_state,
   output hdlctx_pkg::coder_state_type next_saved,
   output hdlctx_pkg::result_pair_type results
);
   import hdlctx_pkg::*;

   typedef struct packed {
      coder_state_type st;
      logic            emit;
      logic [7:0]      data_val;
   } step_type;

   // Sends one line level: optional scrambling, then packing into the partial byte.
   function automatic step_type send_level(coder_state_type st, logic level, logic en);
      step_type r;
      logic     s;
      r          = '0;
      r.st       = st;
      s          = level;
      r.st.line_level = level;
      if (en) begin
         s = level ^ st.scrambler_reg[0] ^ st.scrambler_reg[5];
         r.st.scrambler_reg = {s, st.scrambler_reg[16:1]};
      end
      r.st.partial_bits[st.fill_count] = s;
      r.data_val = r.st.partial_bits;
      if (st.fill_count == 3'd7) begin
         r.emit            = 1'b1;
         r.st.partial_bits = '0;
         r.st.fill_count   = '0;
      end else begin
         r.st.fill_count = st.fill_count + 3'd1;
      end
      return r;
   endfunction

   always_comb begin : coder_logic
      coder_state_type st;
      coder_state_type sv;
      step_type        sp;
      result_type      res0;
      result_type      res1;
      logic [1:0]      n;
      logic            is_byte;

      st      = cur_state;
      sv      = cur_saved;
      res0    = '0;
      res1    = '0;
      n       = '0;
      sp      = '0;
      is_byte = 1'b0;

      case (cmd)
         CMD_STUFFED, CMD_COUNTED, CMD_RAW: is_byte = 1'b1;
         CMD_SAVE:    sv = st;
         CMD_RESTORE: st = sv;
         CMD_FLUSH: begin
            if (st.fill_count != 3'd0) begin
               res0.line_byte  = st.partial_bits;
               res0.out_bits   = {1'b0, st.fill_count};
               n               = 2'd1;
               st.partial_bits = '0;
               st.fill_count   = '0;
            end
         end
         CMD_RESET: begin
            st = '0;
            sv = '0;
         end
         default: ;
      endcase

      if (is_byte) begin
         for (int i = 0; i < 8; i++) begin
            // A one keeps the line level, a zero toggles it.
            sp = send_level(st, data_byte[i] ? st.line_level : ~st.line_level, scramble_en);
            st = sp.st;
            if (sp.emit) begin
               if (n == 2'd0) begin
                  res0.line_byte = sp.data_val;
                  res0.out_bits  = 4'd8;
               end else begin
                  res1.line_byte = sp.data_val;
                  res1.out_bits  = 4'd8;
               end
               n = n + 2'd1;
            end
            if (cmd != CMD_RAW) begin
               if (data_byte[i]) begin
                  st.ones_run = st.ones_run + 8'd1;
               end else begin
                  st.ones_run = '0;
               end
            end
            // The stuffed zero goes out only when the run reaches exactly five.
            if (cmd == CMD_STUFFED && data_byte[i] && st.ones_run == 8'd5) begin
               sp = send_level(st, ~st.line_level, scramble_en);
               st = sp.st;
               st.ones_run = '0;
               if (sp.emit) begin
                  if (n == 2'd0) begin
                     res0.line_byte = sp.data_val;
                     res0.out_bits  = 4'd8;
                  end else begin
                     res1.line_byte = sp.data_val;
                     res1.out_bits  = 4'd8;
                  end
                  n = n + 2'd1;
               end
            end
         end
      end

      res0.last     = (n == 2'd1);
      res1.last     = 1'b1;
      next_state    = st;
      next_saved    = sv;
      results.count = n;
      results.r0    = res0;
      results.r1    = res1;
   end

endmodule

// ----- hw/rtl/hdlctx_rsp_fifo.sv -----
// Result queue: takes up to two results a cycle, delivers one a cycle while pop is high.
`timescale 1ns / 1ps

module hdlctx_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  hdlctx_pkg::result_pair_type         push,
   input  logic                                pop,
   output logic                                head_valid,
   output hdlctx_pkg::result_type              head,
   output logic [hdlctx_pkg::FIFO_CW-1:0]      count
);
   import hdlctx_pkg::*;

   result_type           entries_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 do_pop;

   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(do_pop);
      count_in  = count_ff + FIFO_CW'(push.count) - FIFO_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_ff + FIFO_AW'(1)] <= push.r1;
      end
   end

endmodule

// ----- hw/rtl/hdlc_tx_bit_encoder_unit.sv -----
// Top level of the HDLC transmit bit encoder: input register, coder and result queue.
//
//  channel  direction  payload
//  req      in         tuser[2:0] cmd, tdata[7:0] data_byte
//  rsp      out        tdata[7:0] line_byte, tdata[11:8] out_bits, tlast last
//  csr      in         wr_data scramble_enable, taken whenever wr_en is high
//
// A request is captured in the input register and coded during the following cycle; its
// results are written into an eight-entry queue at the next edge, and the queue offers
// the first result once it is written. One request is taken per cycle while req_tready is
// high; a request that makes two results sends them out one at a time. req_tready drops
// while the queue could not hold the results of the request in flight plus one more.
// Reset clears the coder, checkpoint, queue and scramble_enable.
`timescale 1ns / 1ps

module hdlc_tx_bit_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [2:0]  req_tuser,   // [2:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] line_byte, [11:8] out_bits, [15:12] zero
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import hdlctx_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [2:0]      in_cmd_ff;
   logic [7:0]      in_data_ff;
   logic            scramble_en_ff;
   coder_state_type coder_ff, coder_in;
   coder_state_type saved_ff, saved_in;
   coder_state_type coder_next;
   coder_state_type saved_next;
   result_pair_type coder_res;
   result_pair_type push;
   result_type      head;
   logic            head_valid;
   logic [FIFO_CW-1:0] fifo_count;
   logic            req_accept;

   // Room for the in-flight request's results and then two more.
   assign req_tready = (FIFO_CW'(FIFO_DEPTH) - fifo_count) >=
                       (in_valid_ff ? FIFO_CW'(4) : FIFO_CW'(2));
   assign req_accept = req_tvalid && req_tready;

   hdlctx_coder u_coder (
      .cur_state  (coder_ff),
      .cur_saved  (saved_ff),
      .scramble_en(scramble_en_ff),
      .cmd        (in_cmd_ff),
      .data_byte  (in_data_ff),
      .next_state (coder_next),
      .next_saved (saved_next),
      .results    (coder_res)
   );

   always_comb begin
      in_valid_in = req_accept;
      coder_in    = in_valid_ff ? coder_next : coder_ff;
      saved_in    = in_valid_ff ? saved_next : saved_ff;
      push        = coder_res;
      if (!in_valid_ff) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         scramble_en_ff <= 1'b0;
         coder_ff       <= '0;
         saved_ff       <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         coder_ff    <= coder_in;
         saved_ff    <= saved_in;
         if (csr_wr_en) begin
            scramble_en_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff  <= req_tuser;
         in_data_ff <= req_tdata;
      end
   end

   hdlctx_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_tready),
      .head_valid(head_valid),
      .head      (head),
      .count     (fifo_count)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = {4'b0000, head.out_bits, head.line_byte};
   assign rsp_tlast  = head.last;

endmodule

// ----- sim/hdlc_tx_bit_encoder_unit_tb.sv -----
// Testbench for the HDLC transmit bit encoder, checked against a bit-level coder mirror.
`timescale 1ns / 1ps

module hdlc_tx_bit_encoder_unit_tb;
   import hdlctx_pkg::*;

   class coder_mirror;
      bit              scramble_on;
      logic [7:0]      ones_run;
      logic            level;
      logic [2:0]      fill;
      logic [7:0]      partial;
      logic [16:0]     scram;
      coder_state_type checkpoint;
      result_type      burst[$];
      result_type      due[$];
      int              mistakes;

      function new();
         scramble_on = 1'b0;
         mistakes    = 0;
         clear_coder();
      endfunction

      function void clear_coder();
         ones_run   = '0;
         level      = 1'b0;
         fill       = '0;
         partial    = '0;
         scram      = '0;
         checkpoint = '0;
      endfunction

      function void set_scramble(bit on);
         scramble_on = on;
      endfunction

      function int waiting();
         return due.size();
      endfunction

      function void add_line_byte(logic [7:0] octet, logic [3:0] nbits);
         result_type r;
         r.line_byte = octet;
         r.out_bits  = nbits;
         r.last      = 1'b0;
         burst.push_back(r);
      endfunction

      // The NRZI level is tracked before scrambling; the scrambled bit is what goes on the line.
      function void put_line_bit(logic lvl);
         logic s;
         s     = lvl;
         level = lvl;
         if (scramble_on) begin
            s     = s ^ scram[0] ^ scram[5];
            scram = {s, scram[16:1]};
         end
         partial[fill] = s;
         if (fill == 3'd7) begin
            add_line_byte(partial, 4'd8);
            partial = '0;
            fill    = '0;
         end else begin
            fill = fill + 3'd1;
         end
      endfunction

      function void code_byte(logic [7:0] octet, logic [2:0] mode);
         for (int i = 0; i < 8; i++) begin
            if (octet[i]) begin
               put_line_bit(level);
               if (mode != CMD_RAW) begin
                  ones_run = ones_run + 8'd1;
                  // Only a run that lands exactly on five gets a stuffed zero.
                  if (mode == CMD_STUFFED && ones_run == 8'd5) begin
                     put_line_bit(~level);
                     ones_run = '0;
                  end
               end
            end else begin
               put_line_bit(~level);
               if (mode != CMD_RAW) ones_run = '0;
            end
         end
      endfunction

      function void note_request(logic [2:0] cmd, logic [7:0] octet);
         result_type r;
         int n;
         burst.delete();
         case (cmd)
            CMD_STUFFED, CMD_COUNTED, CMD_RAW: code_byte(octet, cmd);
            CMD_SAVE: begin
               checkpoint.ones_run      = ones_run;
               checkpoint.line_level    = level;
               checkpoint.fill_count    = fill;
               checkpoint.partial_bits  = partial;
               checkpoint.scrambler_reg = scram;
            end
            CMD_RESTORE: begin
               ones_run = checkpoint.ones_run;
               level    = checkpoint.line_level;
               fill     = checkpoint.fill_count;
               partial  = checkpoint.partial_bits;
               scram    = checkpoint.scrambler_reg;
            end
            CMD_FLUSH: begin
               if (fill != 3'd0) begin
                  add_line_byte(partial, {1'b0, fill});
                  partial = '0;
                  fill    = '0;
               end
            end
            CMD_RESET: clear_coder();
            default: ;
         endcase
         n = burst.size();
         for (int i = 0; i < n; i++) begin
            r      = burst[i];
            r.last = (i == n - 1);
            due.push_back(r);
         end
      endfunction

      function void check_result(logic [15:0] word, logic tail);
         result_type want;
         if (due.size() == 0) begin
            $error("unexpected result: line_byte %h out_bits %0d last %b",
                   word[7:0], word[11:8], tail);
            mistakes++;
            return;
         end
         want = due.pop_front();
         if (word[7:0] !== want.line_byte) begin
            $error("line_byte: expected %h, got %h", want.line_byte, word[7:0]);
            mistakes++;
         end
         if (word[11:8] !== want.out_bits) begin
            $error("out_bits: expected %0d, got %0d", want.out_bits, word[11:8]);
            mistakes++;
         end
         if (tail !== want.last) begin
            $error("last: expected %b, got %b", want.last, tail);
            mistakes++;
         end
      endfunction
   endclass

   localparam logic [2:0] CMD_UNUSED  = 3'd7;
   localparam int         DRAIN_PAD   = 8;
   localparam int         STALL_LIMIT = 2000;
   localparam int         PHASE_ITEMS = 200;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic [2:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   coder_mirror board;
   bit          steady      = 1'b0;
   int          sent        = 0;
   int          stall_left  = 0;
   int          idle_cycles = 0;

   hdlc_tx_bit_encoder_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Mostly no gap or a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] random_octet();
      if ($urandom_range(0, 3) == 0) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Valid is only lowered when a gap follows, so back-to-back requests keep it high.
   task automatic send_request(input logic [2:0] cmd, input logic [7:0] octet);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= octet;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cmd, octet);
      if (cmd != CMD_UNUSED) sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.waiting() != 0) @(posedge clock);
      // Requests without results may still be in the pipeline.
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_scramble(input bit on);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_scramble(on);
   endtask

   task automatic send_frame();
      logic [7:0] payload[$];
      int         nhead;
      int         nbody;
      repeat ($urandom_range(1, 3)) send_request(CMD_COUNTED, 8'h7E);
      nhead = $urandom_range(1, 4);
      for (int k = 0; k < nhead; k++) send_request(CMD_STUFFED, random_octet());
      send_request(CMD_SAVE, random_octet());
      nbody = $urandom_range(0, 10);
      for (int k = 0; k < nbody; k++) begin
         payload.push_back(random_octet());
         send_request(CMD_STUFFED, payload[k]);
      end
      // A retry rewinds to the end of the header and sends the payload again.
      if ($urandom_range(0, 3) == 0) begin
         send_request(CMD_RESTORE, random_octet());
         foreach (payload[k]) send_request(CMD_STUFFED, payload[k]);
      end
      send_request(CMD_COUNTED, 8'h7E);
      if ($urandom_range(0, 1) == 0) send_request(CMD_FLUSH, random_octet());
      if ($urandom_range(0, 9) == 0) send_request(CMD_RESET, random_octet());
   endtask

   // A long counted run of ones can wrap the run counter, so the stuffed bytes after it
   // may hit five again.
   task automatic send_counter_wrap();
      repeat ($urandom_range(30, 32)) send_request(CMD_COUNTED, 8'hFF);
      repeat (2) send_request(CMD_STUFFED, 8'hFF);
   endtask

   task automatic run_phase(input int count);
      int target;
      int r;
      target = sent + count;
      while (sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 70) send_frame();
         else if (r < 73) send_counter_wrap();
         else send_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (steady || !rsp_tready) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("hdlc_tx_bit_encoder_unit_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_scramble(1'b1);
      send_request(CMD_STUFFED, 8'hFF);
      send_request(CMD_STUFFED, 8'h00);
      send_request(CMD_COUNTED, 8'hFF);
      send_request(CMD_STUFFED, 8'hFF);
      send_request(CMD_RAW, 8'hFF);
      send_request(CMD_RAW, 8'h00);
      send_request(CMD_SAVE, 8'h00);
      send_request(CMD_STUFFED, 8'hA5);
      send_request(CMD_RESTORE, 8'h00);
      send_request(CMD_FLUSH, 8'h00);
      send_request(CMD_FLUSH, 8'hFF);
      send_request(CMD_UNUSED, 8'hFF);
      send_request(CMD_STUFFED, 8'h7E);
      send_request(CMD_RESET, 8'h00);
      send_request(CMD_RESTORE, 8'hFF);
      send_request(CMD_STUFFED, 8'h3E);
      send_request(CMD_COUNTED, 8'h7E);
      send_request(CMD_FLUSH, 8'h00);
      settle();

      for (int p = 0; p < 4; p++) begin
         write_scramble(p[0]);
         steady = (p == 2);
         run_phase(PHASE_ITEMS);
         settle();
      end

      if (board.mistakes == 0 && board.waiting() == 0) begin
         $display("hdlc_tx_bit_encoder_unit_tb: clean");
      end else begin
         $display("hdlc_tx_bit_encoder_unit_tb: errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/hdlctx_pkg.sv
hw/rtl/hdlctx_coder.sv
hw/rtl/hdlctx_rsp_fifo.sv
hw/rtl/hdlc_tx_bit_encoder_unit.sv
sim/hdlc_tx_bit_encoder_unit_tb.sv
